// ===== src/pzm_pkg.sv =====
// Package for the power-of-two pixel zoom block: widths, register indexes,
// the queued job type and the queue status struct. No dependencies.
`default_nettype none
package pzm_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int MAX_UP_SHIFT  = 3;

  localparam int PIX_W   = 32;
  localparam int COORD_W = 15;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int SHIFT_W = 4;
  localparam int K_W     = 2;
  localparam int OFS_W   = 3;
  localparam int SHR_W   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIMENSION);
  localparam logic [K_W-1:0]   K_MAX     = K_W'(MAX_UP_SHIFT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One source pixel after classification: base destination and block size.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
    logic [K_W-1:0]     k;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== src/pzm_if.sv =====
// Stream interfaces for the pixel zoom: source pixels in, placed pixels out.
// Depends on pzm_pkg.
`default_nettype none
interface pzm_in_if;
  import pzm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface pzm_out_if;
  import pzm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  logic [PIX_W-1:0]   pixel_out;
  logic               run_last;
  modport source (output valid, output dest_x, output dest_y, output pixel_out,
                  output run_last, input ready);
  modport sink   (input valid, input dest_x, input dest_y, input pixel_out,
                  input run_last, output ready);
endinterface
`default_nettype wire

// ===== src/pzm_front.sv =====
// Front end: configuration registers, source column/row counters and
// classification of each pixel into a job (or a drop). Depends on pzm_pkg.
`default_nettype none
module pzm_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pzm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  input  wire logic [pzm_pkg::PIX_W-1:0]      in_pixel,
  output logic                                in_ready,
  input  wire pzm_pkg::qstat_t                qstat,
  output logic                                push,
  output pzm_pkg::job_t                       job
);
  import pzm_pkg::*;

  logic [SHIFT_W-1:0] zoom_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [POS_W-1:0]   col_r, col_nxt, row_r, row_nxt;

  logic [DIM_W-1:0]   w, h;
  logic               accept;
  logic               up;
  logic [K_W-1:0]     k;
  logic [SHR_W-1:0]   m;
  logic [POS_W-1:0]   lowmask;
  logic [DIM_W:0]     half;
  logic [DIM_W:0]     rnd_w, rnd_h;
  logic [POS_W-1:0]   col_sh, row_sh;
  logic               keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r   <= '0;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZOOM_SHIFT:    zoom_r   <= cfg_data[SHIFT_W-1:0];
        REG_SOURCE_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w = DIM_W'(1);
    else if (width_r > DIM_MAX) w = DIM_MAX;
    else w = width_r;
    if (height_r == '0) h = DIM_W'(1);
    else if (height_r > DIM_MAX) h = DIM_MAX;
    else h = height_r;
  end

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // Advance raster position; wrap on reached-or-passed.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if ({1'b0, col_r} + DIM_W'(1) >= w) begin
        col_nxt = '0;
        if ({1'b0, row_r} + DIM_W'(1) >= h) row_nxt = '0;
        else row_nxt = row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Classify: enlarge keeps every pixel, shrink keeps a decimated grid.
  always_comb begin
    up      = !zoom_r[SHIFT_W-1];
    k       = (zoom_r[SHIFT_W-2:0] > 3'(K_MAX)) ? K_MAX : zoom_r[K_W-1:0];
    m       = SHR_W'(~zoom_r + SHIFT_W'(1));
    lowmask = (POS_W'(1) << m) - POS_W'(1);
    half    = (DIM_W+1)'(1) << (m - SHR_W'(1));
    rnd_w   = ({1'b0, w} + half) >> m;
    rnd_h   = ({1'b0, h} + half) >> m;
    col_sh  = col_r >> m;
    row_sh  = row_r >> m;
    keep    = ((col_r & lowmask) == '0) && ((row_r & lowmask) == '0) &&
              ({2'b00, col_sh} < rnd_w) && ({2'b00, row_sh} < rnd_h);
    job.pix = in_pixel;
    if (up) begin
      job.x = COORD_W'({3'b000, col_r} << k);
      job.y = COORD_W'({3'b000, row_r} << k);
      job.k = k;
    end else begin
      job.x = COORD_W'(col_sh);
      job.y = COORD_W'(row_sh);
      job.k = '0;
    end
  end

  assign push = accept && (up || keep);

endmodule
`default_nettype wire

// ===== src/pzm_queue.sv =====
// Short job queue between front and back end, register based.
// Depends on pzm_pkg.
`default_nettype none
module pzm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pzm_pkg::job_t din,
  input  wire logic          pop,
  output pzm_pkg::job_t      dout,
  output pzm_pkg::qstat_t    stat
);
  import pzm_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    if (pop)  rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  assign dout       = mem_r[rd_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

// ===== src/pzm_back.sv =====
// Back end: walks the 2^k by 2^k block of the head job into the output
// register, one result per cycle unless stalled. Depends on pzm_pkg.
`default_nettype none
module pzm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pzm_pkg::job_t   head,
  input  wire pzm_pkg::qstat_t qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [pzm_pkg::COORD_W-1:0] out_x,
  output logic [pzm_pkg::COORD_W-1:0] out_y,
  output logic [pzm_pkg::PIX_W-1:0]   out_pix,
  output logic                        out_last
);
  import pzm_pkg::*;

  logic [OFS_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [OFS_W-1:0]   ofs_max;
  logic               load, last;
  logic               valid_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]   pix_r;
  logic               last_r;

  assign ofs_max = OFS_W'((4'd1 << head.k) - 4'd1);
  assign last    = (i_r == ofs_max) && (j_r == ofs_max);
  assign load    = !qstat.empty && (!valid_r || out_ready);
  assign pop     = load && last;

  // Row offset inner, column offset outer.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (load) begin
      if (last) begin
        i_nxt = '0;
        j_nxt = '0;
      end else if (j_r == ofs_max) begin
        j_nxt = '0;
        i_nxt = i_r + OFS_W'(1);
      end else begin
        j_nxt = j_r + OFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      j_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (load) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= head.x + COORD_W'(i_r);
      y_r    <= head.y + COORD_W'(j_r);
      pix_r  <= head.pix;
      last_r <= last;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_pix   = pix_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// ===== src/power_of_two_pixel_zoom.sv =====
// Top level of the power-of-two pixel zoom: front end, job queue, back end.
// Depends on pzm_pkg, pzm_if, pzm_front, pzm_queue, pzm_back.
//
//   port     dir   handshake        payload
//   in_ch    in    valid/ready      pixel_value
//   out_ch   out   valid/ready      dest_x, dest_y, pixel_out, run_last
//   cfg_*    in    cfg_we only      cfg_index, cfg_data
//
// The back end gives one result per cycle while the output is not stalled:
// an enlarged pixel gives 4^k results (1 to 64), a kept shrunk pixel one,
// a dropped pixel none. The output register in the back end sets that pace.
// Synchronous reset clears counters, queue and output valid; registers take
// zoom 0 and 4096 by 4096. A two-entry queue lets input be accepted while
// the output stalls, until both entries hold jobs.
`default_nettype none
module power_of_two_pixel_zoom (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pzm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pzm_pkg::CFG_DATA_W-1:0] cfg_data,
  pzm_in_if.sink                              in_ch,
  pzm_out_if.source                           out_ch
);
  import pzm_pkg::*;

  job_t   job, head;
  qstat_t qstat;
  logic   push, pop;

  pzm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_pixel  (in_ch.pixel_value),
    .in_ready  (in_ch.ready),
    .qstat     (qstat),
    .push      (push),
    .job       (job)
  );

  pzm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job),
    .pop   (pop),
    .dout  (head),
    .stat  (qstat)
  );

  pzm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.dest_x),
    .out_y     (out_ch.dest_y),
    .out_pix   (out_ch.pixel_out),
    .out_last  (out_ch.run_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full && !pop))
    else $error("job pushed into a full queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.run_last))
    else $error("job retired without a final result in the output register");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

  a_stat_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

endmodule
`default_nettype wire
